// ===== sv/pipeline_hazard_scoreboard_macros.svh =====
// assertion helpers shared by the scoreboard modules
// both expect clk and arst_n in the scope of the module that uses them
`ifndef PIPELINE_HAZARD_SCOREBOARD_MACROS_SVH
`define PIPELINE_HAZARD_SCOREBOARD_MACROS_SVH

// condition in a cycle implies a consequence in the same cycle
`define PHS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("phs: same-cycle check failed");

// condition in a cycle implies a consequence in the next cycle
`define PHS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("phs: next-cycle check failed");

`endif

// ===== sv/phs_pkg.sv =====
`timescale 1ns / 1ps

package phs_pkg;

	// block configuration
	localparam int NUM_REGS       = 32;
	localparam int RESULT_LATENCY = 4;
	localparam int STORE_WINDOW   = 3;
	localparam int STORE_ENTRIES  = 4;

	// field widths
	localparam int OP_W   = 3;
	localparam int REG_W  = 6;
	localparam int OFF_W  = 16;
	localparam int LINE_W = 16;
	localparam int CNT_W  = 16;
	localparam int CD_W   = 3;
	localparam int NOPS_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_MOV   = 3'd0,
		OP_LOAD  = 3'd1,
		OP_STORE = 3'd2,
		OP_ADD   = 3'd3,
		OP_SUB   = 3'd4,
		OP_OR    = 3'd5,
		OP_HLT   = 3'd6,
		OP_NOP   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		HZ_NONE  = 2'd0,
		HZ_REG   = 2'd1,
		HZ_STORE = 2'd2
	} hz_kind_t;

	typedef struct packed {
		op_t              op;
		logic [REG_W-1:0] dest_reg;
		logic [REG_W-1:0] src_a;
		logic [REG_W-1:0] src_b;
		logic             src_b_is_reg;
		logic [OFF_W-1:0] mem_offset;
	} instr_t;

	typedef struct packed {
		logic              accepted;
		hz_kind_t          hazard_kind;
		logic [REG_W-1:0]  conflict_reg;
		logic [LINE_W-1:0] producer_line;
		logic [NOPS_W-1:0] nops_inserted;
		logic              memory_access;
		logic [LINE_W-1:0] line_number;
		logic [CNT_W-1:0]  memory_count;
	} result_t;

endpackage

// ===== sv/phs_if.sv =====
`timescale 1ns / 1ps

// decoded instruction channel
interface phs_instr_if import phs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [REG_W-1:0]  dest_reg;
	logic [REG_W-1:0]  src_a;
	logic [REG_W-1:0]  src_b;
	logic              src_b_is_reg;
	logic [OFF_W-1:0]  mem_offset;

	modport source (output valid, op, dest_reg, src_a, src_b, src_b_is_reg, mem_offset,
		input ready);
	modport sink (input valid, op, dest_reg, src_a, src_b, src_b_is_reg, mem_offset,
		output ready);
endinterface

// hazard report channel
interface phs_result_if import phs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              accepted;
	logic [1:0]        hazard_kind;
	logic [REG_W-1:0]  conflict_reg;
	logic [LINE_W-1:0] producer_line;
	logic [NOPS_W-1:0] nops_inserted;
	logic              memory_access;
	logic [LINE_W-1:0] line_number;
	logic [CNT_W-1:0]  memory_count;

	modport source (output valid, accepted, hazard_kind, conflict_reg, producer_line,
		nops_inserted, memory_access, line_number, memory_count, input ready);
	modport sink (input valid, accepted, hazard_kind, conflict_reg, producer_line,
		nops_inserted, memory_access, line_number, memory_count, output ready);
endinterface

// ===== sv/pipeline_hazard_scoreboard.sv =====
`timescale 1ns / 1ps

// Read-after-write and store-to-load hazard scoreboard. Each decoded instruction
// is captured in an input register, checked against per-register countdowns and
// a small table of recent store addresses, and its report is registered in an
// output register that drives the result port. One instruction per cycle is
// sustained: all countdowns age and compare in parallel and the scoreboard state
// is updated as the item leaves the input register. Only a report held by a low
// result ready stalls the block: it keeps the input register full and drops
// instr.ready in that same cycle. resolve_mode is written through
// cfg_we/cfg_wdata; the user must write it only while idle, and the block does
// not enforce this. 0 rejects an instruction on its first hazard, 1 reports the
// NOPs needed and clears the register countdowns on a hazard. The line counter
// starts at one and wraps at 16 bits.
module pipeline_hazard_scoreboard import phs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	phs_instr_if.sink    instr,
	phs_result_if.source result
);

	logic    resolve_mode_q;
	logic    valid_s1;
	instr_t  item_s1;
	logic    out_free;
	logic    fire;
	result_t res;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolve_mode_q <= 1'b0;
		end else if (cfg_we) begin
			resolve_mode_q <= cfg_wdata;
		end
	end

	// input register handshake
	assign fire        = valid_s1 && out_free;
	assign instr.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			item_s1.op           <= op_t'(instr.op);
			item_s1.dest_reg     <= instr.dest_reg;
			item_s1.src_a        <= instr.src_a;
			item_s1.src_b        <= instr.src_b;
			item_s1.src_b_is_reg <= instr.src_b_is_reg;
			item_s1.mem_offset   <= instr.mem_offset;
		end
	end

	// hazard check and scoreboard state
	phs_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.resolve_mode (resolve_mode_q),
		.item_s1      (item_s1),
		.res          (res)
	);

	// result register
	phs_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

endmodule

// ===== sv/phs_scoreboard.sv =====
`timescale 1ns / 1ps
`include "pipeline_hazard_scoreboard_macros.svh"

module phs_scoreboard import phs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  logic    resolve_mode,
	input  instr_t  item_s1,
	output result_t res
);

	// register countdowns and store table
	logic [CD_W-1:0]  cd_q     [1:NUM_REGS];
	logic [CD_W-1:0]  cd_aged  [1:NUM_REGS];
	logic             sv_q     [STORE_ENTRIES];
	logic [REG_W-1:0] sbase_q  [STORE_ENTRIES];
	logic [OFF_W-1:0] soff_q   [STORE_ENTRIES];
	logic [CD_W-1:0]  scnt_q   [STORE_ENTRIES];
	logic [CD_W-1:0]  scnt_aged[STORE_ENTRIES];
	logic [LINE_W-1:0] line_q;
	logic [CNT_W-1:0]  mem_cnt_q;

	logic [CD_W-1:0] w_sa, w_sb, w_dest, lk_cnt;
	logic [STORE_ENTRIES-1:0] hit, hit_oh, free_oh, min_oh, pick_oh;
	logic [CD_W-1:0] min_cnt;
	logic any_hit, any_free;
	logic [CD_W-1:0] c1, c2;
	hz_kind_t k2;
	logic [REG_W-1:0] r1, r2;
	logic hz1, hz2, ok, mark, clear, store_ins, is_mem, store_fresh;
	logic [CD_W:0] nops_sum;
	logic [LINE_W-1:0] line_after;

	// aging: every live countdown drops by one per item
	always_comb begin
		for (int i = 1; i <= NUM_REGS; i++) begin
			cd_aged[i] = cd_q[i] - CD_W'(cd_q[i] != '0);
		end
		for (int e = 0; e < STORE_ENTRIES; e++) begin
			scnt_aged[e] = scnt_q[e] - CD_W'(scnt_q[e] != '0);
		end
	end

	// countdown read at the three register fields; out of range reads zero
	always_comb begin
		w_sa   = '0;
		w_sb   = '0;
		w_dest = '0;
		for (int i = 1; i <= NUM_REGS; i++) begin
			if (int'(item_s1.src_a) == i) w_sa = cd_aged[i];
			if (int'(item_s1.src_b) == i) w_sb = cd_aged[i];
			if (int'(item_s1.dest_reg) == i) w_dest = cd_aged[i];
		end
	end

	// store table compare, free slot and oldest slot search
	always_comb begin
		hit_oh  = '0;
		free_oh = '0;
		min_oh  = '0;
		lk_cnt  = '0;
		for (int e = 0; e < STORE_ENTRIES; e++) begin
			hit[e] = sv_q[e] && (scnt_aged[e] != '0) && (sbase_q[e] == item_s1.src_a)
				&& (soff_q[e] == item_s1.mem_offset);
		end
		for (int e = STORE_ENTRIES - 1; e >= 0; e--) begin
			if (hit[e]) begin
				hit_oh    = '0;
				hit_oh[e] = 1'b1;
				lk_cnt    = scnt_aged[e];
			end
			if (!sv_q[e] || scnt_aged[e] == '0) begin
				free_oh    = '0;
				free_oh[e] = 1'b1;
			end
		end
		min_cnt   = scnt_aged[0];
		min_oh[0] = 1'b1;
		for (int e = 1; e < STORE_ENTRIES; e++) begin
			if (scnt_aged[e] < min_cnt) begin
				min_cnt   = scnt_aged[e];
				min_oh    = '0;
				min_oh[e] = 1'b1;
			end
		end
		any_hit  = |hit_oh;
		any_free = |free_oh;
		pick_oh  = any_hit ? hit_oh : (any_free ? free_oh : min_oh);
	end

	// hazard checks in program order; a resolved hazard clears registers
	always_comb begin
		c1   = '0;
		c2   = '0;
		k2   = HZ_REG;
		r1   = '0;
		r2   = '0;
		mark = 1'b0;
		case (item_s1.op)
			OP_MOV: begin
				c1   = w_sa;
				r1   = item_s1.src_a;
				mark = 1'b1;
			end
			OP_LOAD: begin
				c1   = w_sa;
				r1   = item_s1.src_a;
				c2   = lk_cnt;
				k2   = HZ_STORE;
				mark = 1'b1;
			end
			OP_STORE: begin
				c1 = w_dest;
				r1 = item_s1.dest_reg;
				c2 = (resolve_mode && w_dest != '0) ? '0 : w_sa;
				r2 = item_s1.src_a;
			end
			OP_ADD, OP_SUB, OP_OR: begin
				c1   = w_sa;
				r1   = item_s1.src_a;
				c2   = (item_s1.src_b_is_reg && !(resolve_mode && w_sa != '0)) ? w_sb : '0;
				r2   = item_s1.src_b;
				mark = 1'b1;
			end
			default: begin
				c1 = '0;
			end
		endcase
	end

	// result assembly
	always_comb begin
		hz1       = (c1 != '0);
		hz2       = (c2 != '0);
		ok        = resolve_mode || (!hz1 && !hz2);
		clear     = resolve_mode && (hz1 || hz2);
		nops_sum  = resolve_mode ? ({1'b0, c1} + {1'b0, c2}) : '0;
		line_after = line_q + LINE_W'(nops_sum);
		is_mem    = ok && (item_s1.op == OP_LOAD || item_s1.op == OP_STORE);
		store_ins = ok && (item_s1.op == OP_STORE);

		res.accepted      = ok;
		res.hazard_kind   = HZ_NONE;
		res.conflict_reg  = '0;
		res.producer_line = '0;
		if (hz1) begin
			res.hazard_kind   = HZ_REG;
			res.conflict_reg  = r1;
			res.producer_line = line_q - LINE_W'(RESULT_LATENCY) + LINE_W'(c1);
		end else if (hz2) begin
			res.hazard_kind   = k2;
			res.conflict_reg  = (k2 == HZ_STORE) ? '0 : r2;
			res.producer_line = line_q + LINE_W'(c2) - ((k2 == HZ_STORE)
				? LINE_W'(STORE_WINDOW) : LINE_W'(RESULT_LATENCY));
		end
		res.nops_inserted = (nops_sum > (CD_W+1)'({NOPS_W{1'b1}})) ? '1
			: NOPS_W'(nops_sum);
		res.memory_access = is_mem;
		res.line_number   = line_after;
		res.memory_count  = (is_mem && mem_cnt_q != '1) ? mem_cnt_q + 1'b1 : mem_cnt_q;
	end

	// state update when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NUM_REGS; i++) cd_q[i] <= '0;
			for (int e = 0; e < STORE_ENTRIES; e++) begin
				sv_q[e]   <= 1'b0;
				scnt_q[e] <= '0;
			end
			line_q    <= LINE_W'(1);
			mem_cnt_q <= '0;
		end else if (fire) begin
			for (int i = 1; i <= NUM_REGS; i++) begin
				if (mark && int'(item_s1.dest_reg) == i) cd_q[i] <= CD_W'(RESULT_LATENCY);
				else if (clear) cd_q[i] <= '0;
				else cd_q[i] <= cd_aged[i];
			end
			for (int e = 0; e < STORE_ENTRIES; e++) begin
				if (store_ins && pick_oh[e]) begin
					sv_q[e]   <= 1'b1;
					scnt_q[e] <= CD_W'(STORE_WINDOW);
				end else begin
					scnt_q[e] <= scnt_aged[e];
				end
			end
			line_q    <= line_after + 1'b1;
			mem_cnt_q <= res.memory_count;
		end
	end

	// store keys carry no reset
	always_ff @(posedge clk) begin
		for (int e = 0; e < STORE_ENTRIES; e++) begin
			if (fire && store_ins && pick_oh[e]) begin
				sbase_q[e] <= item_s1.src_a;
				soff_q[e]  <= item_s1.mem_offset;
			end
		end
	end

	// some slot holds a fresh store window
	always_comb begin
		store_fresh = 1'b0;
		for (int e = 0; e < STORE_ENTRIES; e++) begin
			if (sv_q[e] && scnt_q[e] == CD_W'(STORE_WINDOW)) store_fresh = 1'b1;
		end
	end

	`PHS_ASSERT_SAME(a_resolve_accepts, fire && resolve_mode, res.accepted)
	`PHS_ASSERT_NEXT(a_idle_line_holds, !fire, $stable(line_q))
	`PHS_ASSERT_NEXT(a_reject_count_holds, fire && !res.accepted, $stable(mem_cnt_q))
	`PHS_ASSERT_NEXT(a_store_marks_slot, fire && store_ins, store_fresh)

endmodule

// ===== sv/phs_out_reg.sv =====
`timescale 1ns / 1ps

module phs_out_reg import phs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  result_t       res,
	output logic          free,
	phs_result_if.source  result
);

	logic    valid_q;
	result_t data_q;

	// slot opens when empty or drained this cycle
	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	// drive the channel
	assign result.valid         = valid_q;
	assign result.accepted      = data_q.accepted;
	assign result.hazard_kind   = data_q.hazard_kind;
	assign result.conflict_reg  = data_q.conflict_reg;
	assign result.producer_line = data_q.producer_line;
	assign result.nops_inserted = data_q.nops_inserted;
	assign result.memory_access = data_q.memory_access;
	assign result.line_number   = data_q.line_number;
	assign result.memory_count  = data_q.memory_count;

endmodule
